>>> rtl/ir_range_moving_average_defines.svh
// ----------------------------------------------------------------------------
// IR range moving average: assertion macros
// Concurrent checks on clk_i / rst_ni; empty bodies when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef IR_RANGE_MOVING_AVERAGE_DEFINES_SVH
`define IR_RANGE_MOVING_AVERAGE_DEFINES_SVH

`ifndef SYNTH
`define IRMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define IRMA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define IRMA_ASSERT(lbl, prop, msg)
`define IRMA_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/irma_pkg.sv
// ----------------------------------------------------------------------------
// IR range moving average: shared package
// Widths, queue sizing, transfer type and the distance table functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package irma_pkg;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned AVG_W     = 12;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned ROM_DEPTH = 4096;

  localparam int unsigned Q_DEPTH = 8;
  localparam int unsigned Q_PTR_W = 3;
  localparam int unsigned Q_CNT_W = 4;

  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned MANT_BITS = 30;
  localparam logic [63:0] SCALED_GAIN = 64'd12330800;

  typedef struct packed {
    logic             valid;
    logic [AVG_W-1:0] average;
  } avg_xfer_t;

  function automatic logic [63:0] irma_isqrt(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    int          i;
    v = x;
    r = '0;
    b = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] irma_log2(input logic [63:0] x);
    int          n;
    int          i;
    int          k;
    logic [63:0] m;
    logic [63:0] res;
    n = 0;
    for (i = 1; i < 63; i++) begin
      if ((x >> i) != 64'd0) begin
        n = i;
      end
    end
    if (n > int'(MANT_BITS)) begin
      m = x >> (n - int'(MANT_BITS));
    end else begin
      m = x << (int'(MANT_BITS) - n);
    end
    res = 64'(n) << FRAC_BITS;
    for (k = int'(FRAC_BITS) - 1; k >= 0; k--) begin
      m = (m * m) >> MANT_BITS;
      if (m >= (64'd2 << MANT_BITS)) begin
        m = m >> 1;
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  localparam logic [63:0] LOG2_GAIN = irma_log2(SCALED_GAIN);

  function automatic logic [DIST_W-1:0] irma_distance(input logic [AVG_W-1:0] avg);
    logic [63:0] l;
    logic [63:0] scaled;
    logic [63:0] e;
    logic [63:0] f;
    logic [63:0] v;
    logic [63:0] t;
    int          ip;
    int          k;
    if (avg == '0) begin
      return {DIST_W{1'b1}};
    end
    l      = irma_log2(64'(avg));
    scaled = (64'd147 * l) / 64'd100;
    if (scaled > LOG2_GAIN) begin
      return '0;
    end
    e = LOG2_GAIN - scaled;
    if (e >= (64'd16 << FRAC_BITS)) begin
      return {DIST_W{1'b1}};
    end
    ip = int'(e >> FRAC_BITS);
    f  = e & ((64'd1 << FRAC_BITS) - 64'd1);
    v  = 64'd1 << MANT_BITS;
    for (k = 0; k < int'(FRAC_BITS); k++) begin
      t = f[k] ? (v << 1) : v;
      v = irma_isqrt(t << MANT_BITS);
    end
    v = v >> (int'(MANT_BITS) - ip);
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return DIST_W'(v);
  endfunction

endpackage

>>> rtl/irma_front.sv
// ----------------------------------------------------------------------------
// IR range moving average: front end
// Ring store of the window, running sum, fill tracking and reciprocal divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irma_front import irma_pkg::*; #(
  parameter int unsigned WINDOW = 100
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [Q_CNT_W-1:0]  q_count_i,
  output avg_xfer_t           avg_o
);

  localparam int unsigned PTR_W   = $clog2(WINDOW);
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W = SUM_W + 2;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [SAMPLE_W-1:0] store [WINDOW];

  logic                accept;
  logic [SAMPLE_W-1:0] samp;
  logic [PTR_W-1:0]    wp_q, wp_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic                is_full;
  logic                emit;

  logic                v1_q, emit1_q, sub1_q;
  logic [SAMPLE_W-1:0] samp1_q, old1_q;
  logic                v2_q, v3_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [PROD_W-1:0]   prod_q;
  logic [Q_CNT_W:0]    load;

  assign load = {1'b0, q_count_i} + (Q_CNT_W + 1)'(v1_q) + (Q_CNT_W + 1)'(v2_q)
              + (Q_CNT_W + 1)'(v3_q);
  assign full_o = load >= (Q_CNT_W + 1)'(Q_DEPTH);
  assign accept = push_i && !full_o;
  assign samp   = sample_i;

  assign is_full = fill_q == CNT_W'(WINDOW);
  assign emit    = is_full || (fill_q == CNT_W'(WINDOW - 1));

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (accept) begin
      wp_d = (wp_q == PTR_W'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
      if (!is_full) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (v1_q) begin
      sum_d = sum_q + SUM_W'(samp1_q) - (sub1_q ? SUM_W'(old1_q) : '0);
    end
  end

  // read old slot before overwrite
  always_ff @(posedge clk_i) begin
    if (accept) begin
      old1_q       <= store[wp_q];
      store[wp_q]  <= samp;
      samp1_q      <= samp;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      v1_q    <= 1'b0;
      emit1_q <= 1'b0;
      sub1_q  <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      v1_q    <= accept;
      emit1_q <= emit;
      sub1_q  <= is_full;
      v2_q    <= v1_q && emit1_q;
      v3_q    <= v2_q;
    end
  end

  assign avg_o.valid   = v3_q;
  assign avg_o.average = AVG_W'(prod_q >> SHIFT);

endmodule

>>> rtl/irma_queue.sv
// ----------------------------------------------------------------------------
// IR range moving average: average queue
// Short queue of averages between the front end and the distance lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ir_range_moving_average_defines.svh"

module irma_queue import irma_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  avg_xfer_t          push_i,
  input  logic               pop_i,
  output avg_xfer_t          head_o,
  output logic [Q_CNT_W-1:0] count_o
);

  logic [AVG_W-1:0]   mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.valid) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i.valid && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i.valid) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem[wr_ptr_q] <= push_i.average;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head_o.valid   = cnt_q != '0;
  assign head_o.average = mem[rd_ptr_q];
  assign count_o        = cnt_q;

  `IRMA_NEVER(a_no_overflow, push_i.valid && !pop_i && cnt_q == Q_CNT_W'(Q_DEPTH), "queue overflow")
  `IRMA_NEVER(a_no_underflow, pop_i && cnt_q == '0, "queue underflow")
  `IRMA_ASSERT(a_ptr_track, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q), "queue pointers diverged")

endmodule

>>> rtl/irma_back.sv
// ----------------------------------------------------------------------------
// IR range moving average: back end
// Distance table lookup and result register toward the output queue ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irma_back import irma_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  avg_xfer_t         head_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [AVG_W-1:0]  average_o,
  output logic [DIST_W-1:0] distance_o
);

  logic [DIST_W-1:0] rom_w [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [DIST_W-1:0] ENTRY = irma_distance(AVG_W'(g));
    assign rom_w[g] = ENTRY;
  end

  logic              va_q, va_d;
  logic              vo_q, vo_d;
  logic              adv_a;
  logic              out_rdy;
  logic [AVG_W-1:0]  avg_a_q, avg_o_q;
  logic [DIST_W-1:0] rom_q, dist_o_q;

  assign out_rdy = !vo_q || pop_i;
  assign adv_a   = !va_q || out_rdy;
  assign q_pop_o = head_i.valid && adv_a;

  always_comb begin
    va_d = va_q;
    vo_d = vo_q;
    if (adv_a) begin
      va_d = head_i.valid;
    end
    if (out_rdy) begin
      vo_d = va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      avg_a_q <= head_i.average;
      rom_q   <= rom_w[head_i.average];
    end
    if (out_rdy && va_q) begin
      avg_o_q  <= avg_a_q;
      dist_o_q <= rom_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      va_q <= va_d;
      vo_q <= vo_d;
    end
  end

  assign empty_o    = !vo_q;
  assign average_o  = avg_o_q;
  assign distance_o = dist_o_q;

endmodule

>>> rtl/ir_range_moving_average.sv
// ----------------------------------------------------------------------------
// IR range moving average
// Windowed average of infrared range samples with power-law distance output.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle while full is low. The first
// WINDOW-1 samples only fill the window; from then on every sample yields one
// result: the truncated window average and the distance in unsigned 12.4
// centimetres, saturated at 65535. The rate is set by the ring store, which
// does one read and one write per cycle. A result passes the front pipeline,
// the queue and the back-end registers. Averages wait in an eight-entry queue,
// so full rises only when that queue, counting the samples still in the front
// pipeline, has no room; the window store needs no clearing after reset.
`timescale 1ns / 1ps

module ir_range_moving_average import irma_pkg::*; #(
  parameter int unsigned WINDOW = 100
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                empty,
  input  logic                pop,
  output logic [AVG_W-1:0]    average_o,
  output logic [DIST_W-1:0]   distance_o
);

  avg_xfer_t          avg_push;
  avg_xfer_t          avg_head;
  logic               q_pop;
  logic [Q_CNT_W-1:0] q_count;

  irma_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .sample_i  (sample_i),
    .q_count_i (q_count),
    .avg_o     (avg_push)
  );

  irma_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (avg_push),
    .pop_i   (q_pop),
    .head_o  (avg_head),
    .count_o (q_count)
  );

  irma_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (avg_head),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .average_o  (average_o),
    .distance_o (distance_o)
  );

endmodule
